[sv/sm4ke_pkg.sv]
// sm4ke_pkg: shared types, constants and lookup functions for the sm4 key expansion block
// holds the s-box, the system parameters fk and the round constant generator
// no dependencies
package sm4ke_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumRnd  = 32;
  localparam int unsigned RndW    = $clog2(NumRnd);
  localparam int unsigned NumWin  = 4;
  localparam int unsigned IdxW    = $clog2(NumWin);

  typedef logic [WordW-1:0] word_t;
  typedef logic [RndW-1:0]  rnd_t;
  typedef logic [IdxW-1:0]  idx_t;

  // loading this word position starts a run
  localparam idx_t StartIdx = idx_t'(NumWin - 1);
  localparam rnd_t LastRnd  = rnd_t'(NumRnd - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  localparam word_t Fk [NumWin] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  localparam logic [7:0] Sbox [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return Sbox[b];
  endfunction

  // ck byte j of round i is (4*i + j) * 7 mod 256, byte 0 in the top lane
  function automatic word_t round_const(input rnd_t i);
    word_t      v;
    logic [7:0] pos;
    v = '0;
    for (int j = 0; j < 4; j++) begin
      pos = 8'({i, 2'(j)});
      v   = {v[WordW-9:0], 8'((pos << 3) - pos)};
    end
    return v;
  endfunction

endpackage

[sv/sm4ke_round.sv]
// sm4ke_round: one sm4 key schedule round, s-box layer plus linear map
// depends on sm4ke_pkg for the s-box, word type and round constants
module sm4ke_round (
  input  sm4ke_pkg::word_t win_i [sm4ke_pkg::NumWin],
  input  sm4ke_pkg::rnd_t  rnd_i,
  output sm4ke_pkg::word_t nk_o
);

  sm4ke_pkg::word_t t;
  sm4ke_pkg::word_t s;
  sm4ke_pkg::word_t l;

  assign t = win_i[1] ^ win_i[2] ^ win_i[3] ^ sm4ke_pkg::round_const(rnd_i);

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      s[b*8 +: 8] = sm4ke_pkg::sbox(t[b*8 +: 8]);
    end
  end

  // s ^ rotl13 ^ rotl23
  assign l    = s ^ {s[18:0], s[31:19]} ^ {s[8:0], s[31:9]};
  assign nk_o = l ^ win_i[0];

endmodule

[sv/sm4_key_expansion_top.sv]
// sm4_key_expansion_top: sm4 round key expansion with a shared round unit
// depends on sm4ke_pkg and sm4ke_round
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, word_index_i,     | into block
//          | key_word_i                                |
//  out     | out_valid_o, out_stall_i, round_key_o,    | out of block
//          | round_number_o, last_key_o                |
//
// loading word 3 starts 32 rounds through the single round unit, one round per
// cycle while out_stall_i does not hold a full output register
// in_stall_o is high for the whole run; a round only fires when the output
// register is empty or being taken, so out_stall_i freezes the sequencer
// reset clears the key window, round counter and output valid
module sm4_key_expansion_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  word_index_i,
  input  logic [31:0] key_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] round_key_o,
  output logic [4:0]  round_number_o,
  output logic        last_key_o
);

  sm4ke_pkg::state_e state_q, state_d;
  sm4ke_pkg::word_t  win_q [sm4ke_pkg::NumWin];
  sm4ke_pkg::word_t  win_d [sm4ke_pkg::NumWin];
  sm4ke_pkg::rnd_t   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  sm4ke_pkg::word_t  key_q, key_d;
  sm4ke_pkg::rnd_t   num_q, num_d;
  logic              last_q, last_d;

  sm4ke_pkg::word_t  nk;
  logic              fire;

  sm4ke_round u_round (
    .win_i (win_q),
    .rnd_i (cnt_q),
    .nk_o  (nk)
  );

  assign in_stall_o = (state_q != sm4ke_pkg::ST_IDLE);
  assign fire       = (state_q == sm4ke_pkg::ST_RUN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    key_d       = key_q;
    num_d       = num_q;
    last_d      = last_q;
    case (state_q)
      sm4ke_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          win_d[word_index_i] = key_word_i ^ sm4ke_pkg::Fk[word_index_i];
          if (word_index_i == sm4ke_pkg::StartIdx) begin
            state_d = sm4ke_pkg::ST_RUN;
            cnt_d   = '0;
          end
        end
      end
      sm4ke_pkg::ST_RUN: begin
        if (fire) begin
          // shift the window down, new word enters at the top
          win_d[0]    = win_q[1];
          win_d[1]    = win_q[2];
          win_d[2]    = win_q[3];
          win_d[3]    = nk;
          out_valid_d = 1'b1;
          key_d       = nk;
          num_d       = cnt_q;
          last_d      = (cnt_q == sm4ke_pkg::LastRnd);
          cnt_d       = cnt_q + 1'b1;
          if (cnt_q == sm4ke_pkg::LastRnd) begin
            state_d = sm4ke_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sm4ke_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sm4ke_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < sm4ke_pkg::NumWin; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      win_q       <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    num_q  <= num_d;
    last_q <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign round_key_o    = key_q;
  assign round_number_o = num_q;
  assign last_key_o     = last_q;

endmodule

[test/sm4_key_expansion_top_test.sv]
// sm4_key_expansion_top_test: self-checking testbench for the sm4 round key expansion block
// predicts every round key from its own key window and s-box; depends on sm4ke_pkg
// and sm4_key_expansion_top
`timescale 1ns / 1ps

module sm4_key_expansion_top_test;

  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned TailCycles = 48;
  localparam int unsigned RandLoads  = 310;
  localparam int unsigned MaxPrinted = 100;

  localparam sm4ke_pkg::word_t FkParam [4] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  localparam logic [7:0] SboxLut [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  typedef struct packed {
    sm4ke_pkg::idx_t  idx;
    sm4ke_pkg::word_t word;
  } key_load_t;

  typedef struct packed {
    sm4ke_pkg::word_t rkey;
    sm4ke_pkg::rnd_t  num;
    logic             last;
  } round_key_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  word_index_i   = '0;
  logic [31:0] key_word_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [31:0] round_key_o;
  logic [4:0]  round_number_o;
  logic        last_key_o;

  key_load_t        load_q [$];
  round_key_t       rk_pending [$];
  sm4ke_pkg::word_t kwin [4];

  key_load_t   nxt_load;
  round_key_t  want_rk;
  logic        load_taken = 1'b0;
  int unsigned send_gap   = 0;
  int unsigned in_calm    = 0;
  int unsigned stall_left = 0;
  int unsigned out_calm   = 0;
  int unsigned idle_cyc   = 0;
  int unsigned err_cnt    = 0;
  int unsigned fed        = 0;

  sm4_key_expansion_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .word_index_i   (word_index_i),
    .key_word_i     (key_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .round_key_o    (round_key_o),
    .round_number_o (round_number_o),
    .last_key_o     (last_key_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < MaxPrinted) begin
      $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
    end
    err_cnt++;
  endtask

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic sm4ke_pkg::word_t rand_word();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return sm4ke_pkg::word_t'(1) << $urandom_range(0, sm4ke_pkg::WordW - 1);
    return $urandom();
  endfunction

  task automatic push_load(input sm4ke_pkg::idx_t idx, input sm4ke_pkg::word_t word);
    key_load_t it;
    it.idx  = idx;
    it.word = word;
    load_q.push_back(it);
    fed++;
  endtask

  // stores one master key word; word 3 runs all rounds and queues their keys
  task automatic expand_key_word(input sm4ke_pkg::idx_t idx, input sm4ke_pkg::word_t word);
    sm4ke_pkg::word_t ck;
    sm4ke_pkg::word_t t;
    sm4ke_pkg::word_t s;
    sm4ke_pkg::word_t nk;
    round_key_t       rk;
    kwin[idx] = word ^ FkParam[idx];
    if (idx == sm4ke_pkg::StartIdx) begin
      for (int r = 0; r < sm4ke_pkg::NumRnd; r++) begin
        ck = '0;
        for (int j = 0; j < 4; j++) begin
          ck = {ck[23:0], 8'((4 * r + j) * 7)};
        end
        t = kwin[1] ^ kwin[2] ^ kwin[3] ^ ck;
        for (int b = 0; b < 4; b++) begin
          s[8*b +: 8] = SboxLut[t[8*b +: 8]];
        end
        // l'(s) = s ^ rotl13(s) ^ rotl23(s)
        nk = s ^ {s[18:0], s[31:19]} ^ {s[8:0], s[31:9]} ^ kwin[0];
        kwin[0] = kwin[1];
        kwin[1] = kwin[2];
        kwin[2] = kwin[3];
        kwin[3] = nk;
        rk.rkey = nk;
        rk.num  = sm4ke_pkg::rnd_t'(r);
        rk.last = (sm4ke_pkg::rnd_t'(r) == sm4ke_pkg::LastRnd);
        rk_pending.push_back(rk);
      end
    end
  endtask

  // input side: hold each transaction until taken, then an optional gap
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || load_taken)) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (load_q.size() > 0) begin
        nxt_load     = load_q.pop_front();
        in_valid_i   <= 1'b1;
        word_index_i <= nxt_load.idx;
        key_word_i   <= nxt_load.word;
        if (in_calm > 0) begin
          in_calm  <= in_calm - 1;
          send_gap <= 0;
        end else if ($urandom_range(0, 19) == 0) begin
          in_calm  <= $urandom_range(8, 40);
          send_gap <= 0;
        end else begin
          send_gap <= pick_gap();
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    load_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expand_key_word(sm4ke_pkg::idx_t'(word_index_i), sm4ke_pkg::word_t'(key_word_i));
    end
  end

  // output side: random stall bursts with calm stretches in between
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (out_calm > 0) begin
      out_stall_i <= 1'b0;
      out_calm    <= out_calm - 1;
    end else if ($urandom_range(0, 99) < 70) begin
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b0;
      out_calm    <= $urandom_range(30, 90);
    end else begin
      out_stall_i <= 1'b1;
      stall_left  <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rk_pending.size() == 0) begin
        report_mismatch("unexpected round key", round_key_o, '0);
      end else begin
        want_rk = rk_pending.pop_front();
        if (round_key_o !== want_rk.rkey) begin
          report_mismatch("round_key", round_key_o, want_rk.rkey);
        end
        if (round_number_o !== want_rk.num) begin
          report_mismatch("round_number", 32'(round_number_o), 32'(want_rk.num));
        end
        if (last_key_o !== want_rk.last) begin
          report_mismatch("last_key", 32'(last_key_o), 32'(want_rk.last));
        end
      end
    end
  end

  // ends the run when no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cyc <= 0;
      end else if (idle_cyc >= WatchLimit) begin
        $display("%0t ns: no transaction for %0d cycles", $time, idle_cyc);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
    end
  end

  initial begin
    int unsigned sel;
    int unsigned nparts;
    int          perm [3];
    int          tmp;
    int unsigned k;

    for (int i = 0; i < 4; i++) kwin[i] = '0;

    // start with only the start word: rounds run on an otherwise zeroed window
    push_load(sm4ke_pkg::StartIdx, 32'h0123_4567);
    push_load(2'd0, 32'h0123_4567);
    push_load(2'd1, 32'h89ab_cdef);
    push_load(2'd2, 32'hfedc_ba98);
    push_load(sm4ke_pkg::StartIdx, 32'h7654_3210);
    // restart on the window left by the previous run
    push_load(sm4ke_pkg::StartIdx, 32'hffff_ffff);
    for (int i = 0; i < 3; i++) push_load(sm4ke_pkg::idx_t'(i), '0);
    push_load(sm4ke_pkg::StartIdx, '0);
    for (int i = 0; i < 3; i++) push_load(sm4ke_pkg::idx_t'(i), '1);
    push_load(sm4ke_pkg::StartIdx, '1);
    // overwrites of the same position, out of order
    push_load(2'd0, 32'hdead_beef);
    push_load(2'd0, 32'h8000_0001);
    push_load(2'd2, 32'h1234_5678);
    push_load(2'd2, 32'h7fff_fffe);
    push_load(2'd1, 32'h0000_ffff);
    push_load(sm4ke_pkg::StartIdx, 32'hffff_0000);
    push_load(2'd0, 32'ha5a5_a5a5);
    push_load(2'd1, 32'h5a5a_5a5a);
    push_load(2'd2, 32'ha5a5_a5a5);
    push_load(sm4ke_pkg::StartIdx, 32'h5a5a_5a5a);

    k = fed;
    while (fed < k + RandLoads) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        // full key in shuffled order, sometimes one position loaded twice
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
          tmp = $urandom_range(0, i);
          {perm[i], perm[tmp]} = {perm[tmp], perm[i]};
        end
        for (int i = 0; i < 3; i++) push_load(sm4ke_pkg::idx_t'(perm[i]), rand_word());
        if ($urandom_range(0, 4) == 0) begin
          push_load(sm4ke_pkg::idx_t'($urandom_range(0, 2)), rand_word());
        end
        push_load(sm4ke_pkg::StartIdx, rand_word());
      end else if (sel < 9) begin
        push_load(sm4ke_pkg::idx_t'($urandom_range(0, 3)), rand_word());
      end else begin
        // partial key before the start word
        nparts = $urandom_range(0, 2);
        for (int i = 0; i < nparts; i++) begin
          push_load(sm4ke_pkg::idx_t'($urandom_range(0, 2)), rand_word());
        end
        push_load(sm4ke_pkg::StartIdx, rand_word());
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (load_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (rk_pending.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
